// ----- sv/etk_pkg.sv -----
package etk_pkg;

  localparam int ELITE_MAX_DEFAULT = 8;
  localparam int POP_MAX = 1024;

  localparam int FIT_W = 32;
  localparam int IDX_W = 10;
  localparam int SLOT_W = 3;
  localparam int COUNT_W = 4;
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(2);

  localparam logic signed [FIT_W-1:0] FIT_LARGEST = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_OFFER = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]              command;
    logic signed [FIT_W-1:0] fitness;
    logic [IDX_W-1:0]        individual_index;
    logic [SLOT_W-1:0]       slot;
  } request_t;

  typedef struct packed {
    logic                    kept;
    logic [SLOT_W-1:0]       rank;
    logic signed [FIT_W-1:0] slot_fitness;
    logic [IDX_W-1:0]        slot_individual;
  } result_t;

  typedef struct packed {
    logic signed [FIT_W-1:0] fitness;
    logic [IDX_W-1:0]        individual;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{fitness: FIT_LARGEST, individual: '0};

  typedef struct packed {
    logic   clear;
    logic   offer;
    entry_t cand;
  } cell_ctl_t;

  typedef struct packed {
    logic   found;
    entry_t prev;
  } link_t;

endpackage

// ----- sv/etk_cell.sv -----
module etk_cell (
  input  logic              clk,
  input  logic              rst,
  input  etk_pkg::cell_ctl_t ctl,
  input  logic              in_use,
  input  etk_pkg::link_t    link_in,
  output logic              found_out,
  output logic              take,
  output etk_pkg::entry_t   entry,
  output etk_pkg::entry_t   entry_next
);
  import etk_pkg::*;

  logic beats;
  logic shift;

  assign beats = ctl.cand.fitness < entry.fitness;
  assign take  = ctl.offer && in_use && beats && !link_in.found;
  assign shift = ctl.offer && in_use && link_in.found;
  assign found_out = link_in.found || take;

  always_comb begin
    if (ctl.clear) begin
      entry_next = ENTRY_RESET;
    end else if (shift) begin
      entry_next = link_in.prev;
    end else if (take) begin
      entry_next = ctl.cand;
    end else begin
      entry_next = entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= ENTRY_RESET;
    end else begin
      entry <= entry_next;
    end
  end

endmodule

// ----- sv/elite_top_k_tracker.sv -----
// Channel   | Signals                         | Handshake
// ----------+---------------------------------+-------------------------------
// request   | start, busy, request            | taken when start && !busy
// result    | done, result                    | valid for the one cycle done is high
// config    | cfg_valid, cfg_ready, cfg_data  | written when cfg_valid && cfg_ready
//
// One request per cycle; busy stays low. The registered result, set by the single
// compare-and-shift step through the cell row, appears in the next cycle.
// Reset fills every slot with the largest fitness and sets the count to two.
// The receiver cannot stall: each result is shown for exactly one cycle.
module elite_top_k_tracker #(
  parameter int ELITE_MAX = etk_pkg::ELITE_MAX_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  etk_pkg::request_t             request,
  output logic                          done,
  output etk_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [etk_pkg::COUNT_W-1:0]   cfg_data
);
  import etk_pkg::*;

  localparam int CW = $clog2(ELITE_MAX + 1);
  localparam int IW = (ELITE_MAX > 1) ? $clog2(ELITE_MAX) : 1;

  logic [COUNT_W-1:0] elite_count;
  logic [CW-1:0]      count_eff;
  logic               accept;
  cell_ctl_t          ctl;
  logic [ELITE_MAX-1:0] in_use;
  logic [ELITE_MAX-1:0] take;
  logic [ELITE_MAX:0]   found;
  entry_t             entries [ELITE_MAX];
  entry_t             entries_next [ELITE_MAX];
  link_t              links [ELITE_MAX];
  logic [IW-1:0]      shown;
  entry_t             read_entry;
  logic [SLOT_W-1:0]  rank_hit;
  result_t            result_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_comb begin
    if (elite_count == '0) begin
      count_eff = CW'(1);
    end else if (32'(elite_count) > ELITE_MAX) begin
      count_eff = CW'(ELITE_MAX);
    end else begin
      count_eff = CW'(elite_count);
    end
  end

  assign ctl.clear = accept && (request.command == CMD_CLEAR);
  assign ctl.offer = accept && (request.command == CMD_OFFER)
                     && (32'(request.individual_index) < POP_MAX);
  assign ctl.cand  = '{fitness: request.fitness, individual: request.individual_index};

  assign found[0] = 1'b0;

  for (genvar j = 0; j < ELITE_MAX; j++) begin : g_cell
    assign in_use[j] = 32'(j) < 32'(count_eff);
    if (j == 0) begin : g_head
      assign links[j] = '{found: found[j], prev: ctl.cand};
    end else begin : g_body
      assign links[j] = '{found: found[j], prev: entries[j-1]};
    end
    etk_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .in_use     (in_use[j]),
      .link_in    (links[j]),
      .found_out  (found[j+1]),
      .take       (take[j]),
      .entry      (entries[j]),
      .entry_next (entries_next[j])
    );
  end

  // one-hot take, so OR of the positions gives the rank
  always_comb begin
    rank_hit = '0;
    for (int j = 0; j < ELITE_MAX; j++) begin
      if (take[j]) begin
        rank_hit = rank_hit | SLOT_W'(j);
      end
    end
  end

  always_comb begin
    if (32'(request.slot) < 32'(count_eff)) begin
      shown = IW'(request.slot);
    end else begin
      shown = IW'(count_eff - CW'(1));
    end
  end

  always_comb begin
    read_entry = entries[0];
    for (int j = 0; j < ELITE_MAX; j++) begin
      if (IW'(j) == shown) begin
        read_entry = entries[j];
      end
    end
  end

  always_comb begin
    result_next.kept = found[ELITE_MAX];
    result_next.rank = rank_hit;
    if (request.command == CMD_READ) begin
      result_next.slot_fitness    = read_entry.fitness;
      result_next.slot_individual = read_entry.individual;
    end else begin
      result_next.slot_fitness    = entries_next[0].fitness;
      result_next.slot_individual = entries_next[0].individual;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elite_count <= COUNT_RESET;
      done        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        elite_count <= cfg_data;
      end
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  a_done_follows_request : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result strobe without a request");

  a_single_insert : assert property (@(posedge clk) disable iff (rst)
    $onehot0(take))
    else $error("candidate inserted in more than one cell");

  a_bad_index_dropped : assert property (@(posedge clk) disable iff (rst)
    (accept && request.command == CMD_OFFER && 32'(request.individual_index) >= POP_MAX)
    |=> !result.kept)
    else $error("offer with index outside population was kept");

  a_clear_result : assert property (@(posedge clk) disable iff (rst)
    (accept && request.command == CMD_CLEAR)
    |=> (result.slot_fitness == FIT_LARGEST && !result.kept))
    else $error("clear did not leave best slot at largest fitness");

endmodule
